FILE: src/acs_pkg.sv
// Shared types, constants and the carry automaton step for the correlation sum block.
package acs_pkg;

    localparam int MASK_BITS  = 16;
    localparam int CFG_W      = 16;
    localparam int SWEEP_BITS = 8;
    localparam int SWEEP      = 1 << SWEEP_BITS;
    localparam int FRAC_BITS  = 30;
    localparam int SUM_W      = 40;
    localparam int CNT_W      = $clog2(SWEEP + 1);
    localparam int K_W        = $clog2(MASK_BITS + 1);
    localparam int KT_W       = $clog2(2 * MASK_BITS + 1);
    localparam int SHIFT_W    = $clog2(SUM_W);
    localparam int LO_BITS    = MASK_BITS / 2;
    localparam int IDX_W      = 2;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_W-1:0] IN2_A_RST     = 16'h81e8;
    localparam logic [CFG_W-1:0] OUT_A_RST     = 16'h81ec;
    localparam logic [CFG_W-1:0] IN2_B_RST     = 16'he1a0;
    localparam logic [CFG_W-1:0] XI_OFFSET_RST = 16'h0000;

    typedef enum logic [IDX_W-1:0] {
        CFG_IN2_A     = 2'd0,
        CFG_OUT_A     = 2'd1,
        CFG_IN2_B     = 2'd2,
        CFG_XI_OFFSET = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] in2_a;
        logic [CFG_W-1:0] out_a;
        logic [CFG_W-1:0] in2_b;
        logic [CFG_W-1:0] xi_offset;
    } cfg_t;

    typedef struct packed {
        logic                 valid;
        logic [MASK_BITS-1:0] xi;
    } queue_head_t;

    typedef struct packed {
        logic           alive;
        logic           e;
        logic           neg;
        logic [K_W-1:0] k;
    } auto_t;

    localparam auto_t AUTO_INIT = '{alive: 1'b1, e: 1'b0, neg: 1'b0, k: '0};

    // Run the automaton over bit positions top down to bot.
    function automatic auto_t auto_run(input auto_t s_in,
                                       input logic [MASK_BITS-1:0] a,
                                       input logic [MASK_BITS-1:0] b,
                                       input logic [MASK_BITS-1:0] c,
                                       input int top,
                                       input int bot);
        auto_t      s;
        logic [2:0] f;
        s = s_in;
        for (int p = MASK_BITS - 1; p >= 0; p--) begin
            if (p <= top && p >= bot && s.alive) begin
                f = {c[p], a[p], b[p]};
                if (!s.e) begin
                    if (f == 3'd7) begin
                        s.e = 1'b1;
                    end else if (f != 3'd0) begin
                        s.alive = 1'b0;
                    end
                end else begin
                    s.k = s.k + K_W'(1);
                    case (f) inside
                        3'd0, 3'd3, 3'd5, 3'd6: s.e = 1'b1;
                        default:                s.e = 1'b0;
                    endcase
                    case (f) inside
                        3'd3, 3'd4: s.neg = ~s.neg;
                        default:    s.neg = s.neg;
                    endcase
                end
            end
        end
        return s;
    endfunction

endpackage

FILE: src/addition_correlation_sum.sv
// Top level of the modular addition correlation sum block.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  xi      | xi_valid, xi_stall, xi_mask               | in
//  res     | res_valid, res_stall, corr_sum, valid_terms | out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// One item sweeps 256 theta terms, one theta term per cycle unless held,
// through the registered pipeline stages; consecutive items sweep without a gap.
// A two-entry queue holds waiting items, so input is taken while a sweep runs.
// A stalled result holds the engine only when the next sweep's last term is ready.
// Reset clears control state and loads the default register values.
module addition_correlation_sum
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              xi_valid,
    output logic                              xi_stall,
    input  logic [acs_pkg::CFG_W-1:0]         xi_mask,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic signed [acs_pkg::SUM_W-1:0]  corr_sum,
    output logic [acs_pkg::CNT_W-1:0]         valid_terms,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [acs_pkg::IDX_W-1:0]         cfg_index,
    input  logic [acs_pkg::CFG_W-1:0]         cfg_data
);

    acs_pkg::cfg_t        cfg_reg;
    acs_pkg::queue_head_t q_head;
    logic                 q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.in2_a     <= acs_pkg::IN2_A_RST;
            cfg_reg.out_a     <= acs_pkg::OUT_A_RST;
            cfg_reg.in2_b     <= acs_pkg::IN2_B_RST;
            cfg_reg.xi_offset <= acs_pkg::XI_OFFSET_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (acs_pkg::cfg_idx_t'(cfg_index))
                acs_pkg::CFG_IN2_A:     cfg_reg.in2_a     <= cfg_data;
                acs_pkg::CFG_OUT_A:     cfg_reg.out_a     <= cfg_data;
                acs_pkg::CFG_IN2_B:     cfg_reg.in2_b     <= cfg_data;
                acs_pkg::CFG_XI_OFFSET: cfg_reg.xi_offset <= cfg_data;
                default: ;
            endcase
        end
    end

    acs_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .xi_valid  (xi_valid),
        .xi_stall  (xi_stall),
        .xi_mask   (xi_mask),
        .xi_offset (cfg_reg.xi_offset),
        .q_head    (q_head),
        .q_pop     (q_pop)
    );

    acs_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .corr_sum    (corr_sum),
        .valid_terms (valid_terms)
    );

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head.valid)
        else $error("queue popped while empty");

    a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (xi_valid && !xi_stall) |=> q_head.valid)
        else $error("accepted item missing from queue");

endmodule

FILE: src/acs_front.sv
// Input side: accepts items, applies the xi offset and holds them in a short queue.
module acs_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           xi_valid,
    output logic                           xi_stall,
    input  logic [acs_pkg::CFG_W-1:0]      xi_mask,
    input  logic [acs_pkg::CFG_W-1:0]      xi_offset,
    output acs_pkg::queue_head_t           q_head,
    input  logic                           q_pop
);

    logic [acs_pkg::MASK_BITS-1:0] entry_reg [acs_pkg::Q_DEPTH];
    logic [acs_pkg::Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [acs_pkg::Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [acs_pkg::Q_CNT_W-1:0]   count_reg, count_next;
    logic                          push;

    assign xi_stall     = (count_reg == acs_pkg::Q_CNT_W'(acs_pkg::Q_DEPTH));
    assign push         = xi_valid && !xi_stall;
    assign q_head.valid = (count_reg != '0);
    assign q_head.xi    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == acs_pkg::Q_PTR_W'(acs_pkg::Q_DEPTH - 1))
                          ? '0 : wr_ptr_reg + acs_pkg::Q_PTR_W'(1);
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == acs_pkg::Q_PTR_W'(acs_pkg::Q_DEPTH - 1))
                          ? '0 : rd_ptr_reg + acs_pkg::Q_PTR_W'(1);
        end
        if (push && !q_pop) begin
            count_next = count_reg + acs_pkg::Q_CNT_W'(1);
        end else if (!push && q_pop) begin
            count_next = count_reg - acs_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= acs_pkg::MASK_BITS'(xi_mask ^ xi_offset);
        end
    end

endmodule

FILE: src/acs_back.sv
// Sweep engine: issues 256 theta terms per item, runs both automata in two stages, accumulates.
module acs_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  acs_pkg::cfg_t                     cfg,
    input  acs_pkg::queue_head_t              q_head,
    output logic                              q_pop,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic signed [acs_pkg::SUM_W-1:0]  corr_sum,
    output logic [acs_pkg::CNT_W-1:0]         valid_terms
);

    localparam int MB = acs_pkg::MASK_BITS;

    logic                             busy_reg, busy_next;
    logic [acs_pkg::SWEEP_BITS-1:0]   idx_reg, idx_next;
    logic [MB-1:0]                    xi_reg, xi_next;
    logic                             adv;
    logic                             issue_last;
    logic [MB-1:0]                    theta_i;
    logic [MB-1:0]                    in2_a, out_a, in2_b;

    logic                             a_valid_reg;
    logic                             a_first_reg, a_last_reg;
    logic [acs_pkg::SWEEP_BITS-1:0]   a_idx_reg;
    logic [MB-1:0]                    a_xi_reg;
    acs_pkg::auto_t                   a_st1_reg, a_st2_reg;
    logic [MB-1:0]                    theta_a;
    acs_pkg::auto_t                   lo_st1, lo_st2;

    logic                             b_valid_reg;
    logic                             b_first_reg, b_last_reg;
    logic                             b_ok_reg, b_neg_reg;
    logic [acs_pkg::KT_W-1:0]         b_kt_reg;

    logic [acs_pkg::SUM_W-1:0]        sum_reg;
    logic [acs_pkg::CNT_W-1:0]        cnt_reg;
    logic [acs_pkg::SUM_W-1:0]        sum_base, mag, acc;
    logic [acs_pkg::CNT_W-1:0]        cnt_base, cnt_acc;
    logic [acs_pkg::SHIFT_W-1:0]      shamt;

    logic                             res_valid_reg, res_valid_next;
    logic [acs_pkg::SUM_W-1:0]        res_sum_reg;
    logic [acs_pkg::CNT_W-1:0]        res_cnt_reg;

    assign in2_a = MB'(cfg.in2_a);
    assign out_a = MB'(cfg.out_a);
    assign in2_b = MB'(cfg.in2_b);

    assign adv        = !(b_valid_reg && b_last_reg && res_valid_reg && res_stall);
    assign issue_last = busy_reg && (idx_reg == '1);
    assign q_pop      = adv && q_head.valid && (!busy_reg || issue_last);
    assign theta_i    = MB'(idx_reg) << (MB - acs_pkg::SWEEP_BITS);
    assign theta_a    = MB'(a_idx_reg) << (MB - acs_pkg::SWEEP_BITS);

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        xi_next   = xi_reg;
        if (adv) begin
            if (busy_reg) begin
                idx_next = idx_reg + acs_pkg::SWEEP_BITS'(1);
            end
            if (q_pop) begin
                busy_next = 1'b1;
                idx_next  = '0;
                xi_next   = q_head.xi;
            end else if (issue_last) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg    <= 1'b0;
            idx_reg     <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            if (adv) begin
                a_valid_reg <= busy_reg;
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        xi_reg <= xi_next;
        if (adv) begin
            a_first_reg <= (idx_reg == '0);
            a_last_reg  <= issue_last;
            a_idx_reg   <= idx_reg;
            a_xi_reg    <= xi_reg;
            a_st1_reg   <= acs_pkg::auto_run(acs_pkg::AUTO_INIT, theta_i, in2_a, out_a,
                                             MB - 1, acs_pkg::LO_BITS);
            a_st2_reg   <= acs_pkg::auto_run(acs_pkg::AUTO_INIT, xi_reg, in2_b, theta_i,
                                             MB - 1, acs_pkg::LO_BITS);
        end
    end

    assign lo_st1 = acs_pkg::auto_run(a_st1_reg, theta_a, in2_a, out_a,
                                      acs_pkg::LO_BITS - 1, 0);
    assign lo_st2 = acs_pkg::auto_run(a_st2_reg, a_xi_reg, in2_b, theta_a,
                                      acs_pkg::LO_BITS - 1, 0);

    always_ff @(posedge clk)
    begin
        if (adv) begin
            b_first_reg <= a_first_reg;
            b_last_reg  <= a_last_reg;
            b_ok_reg    <= lo_st1.alive && lo_st2.alive;
            b_neg_reg   <= lo_st1.neg ^ lo_st2.neg;
            b_kt_reg    <= acs_pkg::KT_W'(lo_st1.k) + acs_pkg::KT_W'(lo_st2.k);
        end
    end

    always_comb
    begin
        sum_base = b_first_reg ? '0 : sum_reg;
        cnt_base = b_first_reg ? '0 : cnt_reg;
        shamt    = acs_pkg::SHIFT_W'(acs_pkg::FRAC_BITS) - acs_pkg::SHIFT_W'(b_kt_reg);
        if (b_kt_reg > acs_pkg::KT_W'(acs_pkg::FRAC_BITS)) begin
            mag = '0;
        end else begin
            mag = acs_pkg::SUM_W'(1) << shamt;
        end
        if (b_ok_reg) begin
            acc     = b_neg_reg ? (sum_base - mag) : (sum_base + mag);
            cnt_acc = cnt_base + acs_pkg::CNT_W'(1);
        end else begin
            acc     = sum_base;
            cnt_acc = cnt_base;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg && res_stall;
        if (adv && b_valid_reg && b_last_reg) begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && b_valid_reg) begin
            sum_reg <= acc;
            cnt_reg <= cnt_acc;
            if (b_last_reg) begin
                res_sum_reg <= acc;
                res_cnt_reg <= cnt_acc;
            end
        end
    end

    assign res_valid   = res_valid_reg;
    assign corr_sum    = $signed(res_sum_reg);
    assign valid_terms = res_cnt_reg;

endmodule
